// ----- src/led_frame_deframer_top_defines.svh -----
// Assertion macros shared by the LED frame deframer RTL.
// No dependencies; files that assert include this header by name.
`ifndef LED_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define LED_FRAME_DEFRAMER_TOP_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define LFD_ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define LFD_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ----- src/lfd_pkg.sv -----
// Shared types, constants and table functions for the LED frame deframer.
// No dependencies.
`default_nettype none

package lfd_pkg;

  localparam int unsigned LFD_VALUE_COUNT = 1024;

  localparam int unsigned EVT_W = 2;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned VAL_W = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned OUT_TDATA_W = 32;

  localparam logic [BYTE_W-1:0] BYTE_00 = 8'h00;
  localparam logic [BYTE_W-1:0] BYTE_F0 = 8'hf0;
  localparam logic [BYTE_W-1:0] BYTE_FF = 8'hff;

  typedef enum logic [EVT_W-1:0] {
    EVT_WORD = 2'd0,
    EVT_FILL = 2'd1,
    EVT_GOOD = 2'd2,
    EVT_BAD  = 2'd3
  } evt_e;

  typedef enum logic [2:0] {
    CLS_ZERO = 3'd0,
    CLS_LOW  = 3'd1,
    CLS_F0   = 3'd2,
    CLS_HIGH = 3'd3,
    CLS_FF   = 3'd4
  } cls_e;

  typedef enum logic [3:0] {
    ST_GOOD       = 4'd0,
    ST_GOOD_00    = 4'd1,
    ST_GOOD_OTHER = 4'd2,
    ST_GOOD_FF    = 4'd3,
    ST_GOOD_FF2   = 4'd4,
    ST_GOOD_FF3   = 4'd5,
    ST_BAD        = 4'd6,
    ST_BAD_FF     = 4'd7,
    ST_BAD_FF2    = 4'd8,
    ST_BAD_FF3    = 4'd9,
    ST_END_GOOD   = 4'd10,
    ST_END_BAD    = 4'd11
  } sync_st_e;

  typedef struct packed {
    evt_e              evt;
    logic [IDX_W-1:0]  index;
    logic [VAL_W-1:0]  value;
  } lfd_res_t;

  function automatic cls_e byte_class(input logic [BYTE_W-1:0] b);
    cls_e c;
    if (b == BYTE_00)      c = CLS_ZERO;
    else if (b < BYTE_F0)  c = CLS_LOW;
    else if (b == BYTE_F0) c = CLS_F0;
    else if (b == BYTE_FF) c = CLS_FF;
    else                   c = CLS_HIGH;
    return c;
  endfunction

  // End-mark search: FF FF FF F0, good/bad flavor tracked by the state.
  function automatic sync_st_e sync_next(input sync_st_e st, input cls_e c);
    sync_st_e ns;
    unique case (st)
      ST_GOOD: begin
        if (c == CLS_ZERO)    ns = ST_GOOD_00;
        else if (c == CLS_FF) ns = ST_GOOD_FF;
        else                  ns = ST_GOOD_OTHER;
      end
      ST_GOOD_00:    ns = ST_GOOD;
      ST_GOOD_OTHER: ns = (c == CLS_FF) ? ST_BAD_FF : ST_GOOD;
      ST_GOOD_FF:    ns = (c == CLS_FF) ? ST_GOOD_FF2 : ST_GOOD;
      ST_GOOD_FF2:   ns = (c == CLS_FF) ? ST_GOOD_FF3 : ST_BAD;
      ST_GOOD_FF3: begin
        if (c == CLS_F0)      ns = ST_END_GOOD;
        else if (c == CLS_FF) ns = ST_BAD_FF3;
        else                  ns = ST_BAD;
      end
      ST_BAD_FF:  ns = (c == CLS_FF) ? ST_BAD_FF2 : ST_BAD;
      ST_BAD_FF2: ns = (c == CLS_FF) ? ST_BAD_FF3 : ST_BAD;
      ST_BAD_FF3: begin
        if (c == CLS_F0)      ns = ST_END_BAD;
        else if (c == CLS_FF) ns = ST_BAD_FF3;
        else                  ns = ST_BAD;
      end
      // plain bad, and unreachable codes treated as bad
      default:    ns = (c == CLS_FF) ? ST_BAD_FF : ST_BAD;
    endcase
    return ns;
  endfunction

endpackage

`default_nettype wire

// ----- src/lfd_deframe_core.sv -----
// Deframer state and per-byte step logic: word pairing, slot counter, sync FSM.
// Depends on lfd_pkg and led_frame_deframer_top_defines.svh.
`default_nettype none
`include "led_frame_deframer_top_defines.svh"

module lfd_deframe_core #(
  parameter int unsigned VALUE_COUNT = lfd_pkg::LFD_VALUE_COUNT
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         step_i,
  input  wire logic [lfd_pkg::BYTE_W-1:0]   byte_i,
  output logic                              res_vld_o,
  output lfd_pkg::lfd_res_t                 res_o
);

  localparam int unsigned CntW = (VALUE_COUNT > 1) ? $clog2(VALUE_COUNT) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(VALUE_COUNT - 1);

  logic                          sync_q, sync_d;
  logic                          hi_q, hi_d;
  logic [lfd_pkg::BYTE_W-1:0]    low_q, low_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  lfd_pkg::sync_st_e             st_q, st_d;
  lfd_pkg::sync_st_e             st_nxt;
  logic [CntW+lfd_pkg::IDX_W-1:0] cnt_ext;

  assign cnt_ext = {{lfd_pkg::IDX_W{1'b0}}, cnt_q};
  assign st_nxt  = lfd_pkg::sync_next(st_q, lfd_pkg::byte_class(byte_i));

  always_comb begin
    sync_d    = sync_q;
    hi_d      = hi_q;
    low_d     = low_q;
    cnt_d     = cnt_q;
    st_d      = st_q;
    res_vld_o = 1'b0;
    res_o     = '0;
    if (!sync_q) begin
      if (!hi_q) begin
        low_d = byte_i;
        hi_d  = 1'b1;
      end else begin
        hi_d        = 1'b0;
        res_vld_o   = 1'b1;
        res_o.index = cnt_ext[lfd_pkg::IDX_W-1:0];
        // word above 0xff00: high byte FF with nonzero low byte
        if (byte_i == lfd_pkg::BYTE_FF && low_q != lfd_pkg::BYTE_00) begin
          sync_d    = 1'b1;
          st_d      = (low_q == lfd_pkg::BYTE_FF) ? lfd_pkg::ST_GOOD_FF2
                                                  : lfd_pkg::ST_BAD_FF;
          res_o.evt = lfd_pkg::EVT_FILL;
        end else begin
          res_o.evt   = lfd_pkg::EVT_WORD;
          res_o.value = {byte_i, low_q};
          if (cnt_q == CntLast) begin
            sync_d = 1'b1;
            st_d   = lfd_pkg::ST_GOOD;
            cnt_d  = '0;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
    end else begin
      if (st_nxt == lfd_pkg::ST_END_GOOD || st_nxt == lfd_pkg::ST_END_BAD) begin
        sync_d    = 1'b0;
        hi_d      = 1'b0;
        cnt_d     = '0;
        st_d      = lfd_pkg::ST_GOOD;
        res_vld_o = 1'b1;
        res_o.evt = (st_nxt == lfd_pkg::ST_END_GOOD) ? lfd_pkg::EVT_GOOD
                                                     : lfd_pkg::EVT_BAD;
      end else begin
        st_d = st_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= 1'b0;
      hi_q   <= 1'b0;
      low_q  <= '0;
      cnt_q  <= '0;
      st_q   <= lfd_pkg::ST_GOOD;
    end else if (step_i) begin
      sync_q <= sync_d;
      hi_q   <= hi_d;
      low_q  <= low_d;
      cnt_q  <= cnt_d;
      st_q   <= st_d;
    end
  end

  // low byte of a pair only gets held
  `LFD_ASSERT_NEVER(a_low_byte_silent, step_i && !sync_q && !hi_q && res_vld_o,
                    "result produced for a low byte")
  // fill event only on a completed pair in the word phase
  `LFD_ASSERT_HOLDS(a_fill_on_pair,
                    res_vld_o && res_o.evt == lfd_pkg::EVT_FILL |-> !sync_q && hi_q,
                    "fill event outside a high byte")
  // frame end restarts the word phase at slot 0
  `LFD_ASSERT_HOLDS(a_end_restarts,
                    step_i && res_vld_o && (res_o.evt == lfd_pkg::EVT_GOOD ||
                    res_o.evt == lfd_pkg::EVT_BAD) |=> !sync_q && !hi_q && cnt_q == '0,
                    "frame end did not restart word phase")
  `LFD_ASSERT_NEVER(a_cnt_range, cnt_q > CntLast, "slot counter beyond frame size")

endmodule

`default_nettype wire

// ----- src/lfd_out_reg.sv -----
// Result register for the master stream side, loads when empty or drained.
// Depends on lfd_pkg.
`default_nettype none

module lfd_out_reg (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,
  input  wire lfd_pkg::lfd_res_t    res_i,
  output logic                      ready_o,
  output logic                      valid_o,
  input  wire logic                 take_i,
  output lfd_pkg::lfd_res_t         res_o
);

  logic              vld_q;
  lfd_pkg::lfd_res_t res_q;

  assign ready_o = !vld_q || take_i;
  assign valid_o = vld_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

// ----- src/led_frame_deframer_top.sv -----
// LED frame deframer top level: input byte register, step core, result register.
// Depends on lfd_pkg, lfd_deframe_core, lfd_out_reg.
//
//  channel  dir  tdata bits (low to high)                          notes
//  s_axis   in   [7:0] data_byte                                   one received byte
//  m_axis   out  [1:0] event_res, [11:2] slot_index,               [31:28] zero
//                [27:12] slot_value
//
// One byte per cycle sustained while m_axis_tready is high: a byte sits in
// the input register while the core steps it, and the result lands in the
// output register. The result word is registered, so it can be taken only
// after its byte has passed the input register and the core.
// A low byte of a pair and most sync-phase bytes give no result word.
// m_axis_tready low stalls the core and then the input once the input register
// is full; no byte or result is dropped. Reset clears all control state.
`default_nettype none

module led_frame_deframer_top #(
  parameter int unsigned VALUE_COUNT = lfd_pkg::LFD_VALUE_COUNT
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  input  wire logic [lfd_pkg::BYTE_W-1:0]        s_axis_tdata_i,  // [7:0] data_byte
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // [1:0] event_res, [11:2] slot_index, [27:12] slot_value, [31:28] zero
  output logic [lfd_pkg::OUT_TDATA_W-1:0]        m_axis_tdata_o
);

  localparam int unsigned ResW = lfd_pkg::EVT_W + lfd_pkg::IDX_W + lfd_pkg::VAL_W;

  logic                        in_vld_q;
  logic [lfd_pkg::BYTE_W-1:0]  in_byte_q;
  logic                        out_rdy;
  logic                        advance;
  logic                        core_vld;
  lfd_pkg::lfd_res_t           core_res;
  lfd_pkg::lfd_res_t           out_res;

  // core steps the held byte whenever the result register can take a word
  assign advance         = in_vld_q && out_rdy;
  assign s_axis_tready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  lfd_deframe_core #(
    .VALUE_COUNT(VALUE_COUNT)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .byte_i    (in_byte_q),
    .res_vld_o (core_vld),
    .res_o     (core_res)
  );

  lfd_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance && core_vld),
    .res_i   (core_res),
    .ready_o (out_rdy),
    .valid_o (m_axis_tvalid_o),
    .take_i  (m_axis_tready_i),
    .res_o   (out_res)
  );

  // pack fields lowest first, zero pad to whole bytes
  assign m_axis_tdata_o = {{(lfd_pkg::OUT_TDATA_W - ResW){1'b0}},
                           out_res.value, out_res.index, out_res.evt};

endmodule

`default_nettype wire

// ----- tb/led_frame_deframer_top_test.sv -----
// Self-checking testbench for led_frame_deframer_top: byte stream in, slot events out.
// Depends on lfd_pkg (types, widths, byte constants) and the RTL top level only.
module led_frame_deframer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lfd_pkg::*;

  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES   = 12;
  localparam int unsigned FRAME_SLOTS    = LFD_VALUE_COUNT;
  localparam int unsigned RANDOM_BYTES   = 2000;
  localparam int unsigned FULL_FRAMES    = 1;
  localparam int unsigned HOLD_CYCLES    = 400;   // long receiver hold-off
  localparam int unsigned TAIL_CYCLES    = 8;     // short pipeline, with margin
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned MAX_REPORTS    = 10;

  // words above this end the word phase; the all-ones word enters sync "good"
  localparam int unsigned FILL_LIMIT = 16'hff00;
  localparam int unsigned WORD_SYNC  = 16'hffff;

  // result word layout on m_axis_tdata
  localparam int unsigned IDX_LSB = EVT_W;
  localparam int unsigned VAL_LSB = EVT_W + IDX_W;
  localparam int unsigned PAD_LSB = EVT_W + IDX_W + VAL_W;

  localparam lfd_res_t NO_RES = '{EVT_WORD, 10'd0, 16'h0000};

  // How a directed row is checked: by the predictor, typed "no result",
  // or typed result.
  typedef enum logic [1:0] {
    ROW_PRED,
    ROW_NONE,
    ROW_RES
  } row_kind_e;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    row_kind_e         kind;
    lfd_res_t          res;
  } stim_row_t;

  localparam int unsigned DIRECTED_ROWS = 24;

  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // word phase from reset: zero word, then the largest plain word
    '{8'h00, ROW_NONE, NO_RES},
    '{8'h00, ROW_RES,  '{EVT_WORD, 10'd0, 16'h0000}},
    '{8'h00, ROW_NONE, NO_RES},
    '{8'hff, ROW_RES,  '{EVT_WORD, 10'd1, 16'hff00}},
    '{8'h34, ROW_NONE, NO_RES},
    '{8'h12, ROW_PRED, NO_RES},
    // smallest word above the limit: fill from slot 3, sync starts bad
    '{8'h01, ROW_NONE, NO_RES},
    '{8'hff, ROW_RES,  '{EVT_FILL, 10'd3, 16'h0000}},
    '{8'hff, ROW_PRED, NO_RES},
    '{8'hff, ROW_PRED, NO_RES},
    '{8'hf0, ROW_RES,  '{EVT_BAD, 10'd0, 16'h0000}},
    // all-ones word: fill from slot 0, sync starts good with FF FF seen
    '{8'hff, ROW_NONE, NO_RES},
    '{8'hff, ROW_RES,  '{EVT_FILL, 10'd0, 16'h0000}},
    '{8'hff, ROW_PRED, NO_RES},
    '{8'hf0, ROW_RES,  '{EVT_GOOD, 10'd0, 16'h0000}},
    // bad start, then every byte class before the end mark
    '{8'h01, ROW_NONE, NO_RES},
    '{8'hff, ROW_RES,  '{EVT_FILL, 10'd0, 16'h0000}},
    '{8'h00, ROW_PRED, NO_RES},
    '{8'h7f, ROW_PRED, NO_RES},
    '{8'hf5, ROW_PRED, NO_RES},
    '{8'hff, ROW_PRED, NO_RES},
    '{8'hff, ROW_PRED, NO_RES},
    '{8'hff, ROW_PRED, NO_RES},
    '{8'hf0, ROW_RES,  '{EVT_BAD, 10'd0, 16'h0000}}
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [BYTE_W-1:0]      s_axis_tdata_i;   // [7:0] data_byte
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  // [1:0] event_res, [11:2] slot_index, [27:12] slot_value, [31:28] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  led_frame_deframer_top #(
    .VALUE_COUNT(FRAME_SLOTS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Deframer predictor: own copy of the block state, at reset values.
  // ---------------------------------------------------------------------
  bit                in_sync    = 1'b0;
  bit                high_due   = 1'b0;
  logic [BYTE_W-1:0] low_held   = '0;
  int unsigned       next_slot  = 0;
  sync_st_e          sync_state = ST_GOOD;

  lfd_res_t slot_events_q[$];   // expected events, oldest first

  int unsigned mismatch_cnt = 0;
  int unsigned bytes_sent   = 0;
  int unsigned burst_left   = 0;
  bit          hold_req     = 1'b0;

  function automatic cls_e class_of(input logic [BYTE_W-1:0] b);
    if (b == BYTE_00) return CLS_ZERO;
    if (b == BYTE_FF) return CLS_FF;
    if (b == BYTE_F0) return CLS_F0;
    return (b > BYTE_F0) ? CLS_HIGH : CLS_LOW;
  endfunction

  // End-mark search, organized by byte class: FF moves along the FF chain,
  // F0 closes a frame after three FFs, anything else falls back.
  function automatic sync_st_e sync_advance(input sync_st_e st, input cls_e c);
    sync_st_e ns;
    ns = ST_BAD;
    if (c == CLS_FF) begin
      case (st)
        ST_GOOD:       ns = ST_GOOD_FF;
        ST_GOOD_00:    ns = ST_GOOD;
        ST_GOOD_OTHER: ns = ST_BAD_FF;
        ST_GOOD_FF:    ns = ST_GOOD_FF2;
        ST_GOOD_FF2:   ns = ST_GOOD_FF3;
        ST_BAD_FF:     ns = ST_BAD_FF2;
        ST_GOOD_FF3, ST_BAD_FF2, ST_BAD_FF3: ns = ST_BAD_FF3;
        default:       ns = ST_BAD_FF;
      endcase
    end else begin
      case (st)
        ST_GOOD:     ns = (c == CLS_ZERO) ? ST_GOOD_00 : ST_GOOD_OTHER;
        ST_GOOD_00, ST_GOOD_OTHER, ST_GOOD_FF: ns = ST_GOOD;
        ST_GOOD_FF3: ns = (c == CLS_F0) ? ST_END_GOOD : ST_BAD;
        ST_BAD_FF3:  ns = (c == CLS_F0) ? ST_END_BAD : ST_BAD;
        default:     ns = ST_BAD;
      endcase
    end
    return ns;
  endfunction

  // Steps one byte; returns 1 with the event in ev when the byte causes one.
  function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output lfd_res_t ev);
    logic [VAL_W-1:0] word;
    sync_st_e         ns;
    ev = NO_RES;
    if (!in_sync) begin
      if (!high_due) begin
        low_held = b;
        high_due = 1'b1;
        return 1'b0;
      end
      high_due = 1'b0;
      word     = {b, low_held};
      ev.index = next_slot[IDX_W-1:0];
      if (word > FILL_LIMIT) begin
        in_sync    = 1'b1;
        sync_state = (word == WORD_SYNC) ? ST_GOOD_FF2 : ST_BAD_FF;
        ev.evt     = EVT_FILL;
        return 1'b1;
      end
      ev.value = word;
      if (next_slot + 1 >= FRAME_SLOTS) begin
        // frame full: sync starts clean, no fill event
        in_sync    = 1'b1;
        sync_state = ST_GOOD;
        next_slot  = 0;
      end else begin
        next_slot++;
      end
      return 1'b1;
    end
    ns = sync_advance(sync_state, class_of(b));
    if (ns == ST_END_GOOD || ns == ST_END_BAD) begin
      in_sync    = 1'b0;
      high_due   = 1'b0;
      next_slot  = 0;
      sync_state = ST_GOOD;
      ev.evt     = (ns == ST_END_GOOD) ? EVT_GOOD : EVT_BAD;
      return 1'b1;
    end
    sync_state = ns;
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------
  // Sender: bursts of random length, random gaps; called at a falling edge
  // and returns at a falling edge once the byte is accepted.
  // ---------------------------------------------------------------------
  task automatic send_byte(input logic [BYTE_W-1:0] b, input row_kind_e kind,
                           input lfd_res_t typed);
    int unsigned gap;
    lfd_res_t    ev;
    bit          has_ev;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 32);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    s_axis_tdata_i  <= b;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    burst_left--;
    bytes_sent++;
    has_ev = deframe_byte(b, ev);
    case (kind)
      ROW_PRED: if (has_ev) slot_events_q.push_back(ev);
      ROW_RES:  slot_events_q.push_back(typed);
      default:  ;  // typed as no result
    endcase
    @(negedge clk_i);
  endtask

  task automatic send_word(input logic [VAL_W-1:0] w);
    send_byte(w[7:0], ROW_PRED, NO_RES);
    send_byte(w[15:8], ROW_PRED, NO_RES);
  endtask

  task automatic send_end_mark();
    send_byte(BYTE_FF, ROW_PRED, NO_RES);
    send_byte(BYTE_FF, ROW_PRED, NO_RES);
    send_byte(BYTE_FF, ROW_PRED, NO_RES);
    send_byte(BYTE_F0, ROW_PRED, NO_RES);
  endtask

  // Drop valid and idle until every expected event has come out.
  task automatic wait_events_drained();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    do @(negedge clk_i); while (slot_events_q.size() != 0);
  endtask

  // A byte from one of the five sync classes, evenly spread over classes.
  function automatic logic [BYTE_W-1:0] pick_class_byte();
    logic [BYTE_W-1:0] b;
    case ($urandom_range(0, 4))
      0:       b = BYTE_00;
      1:       b = BYTE_W'($urandom_range(8'h01, 8'hef));
      2:       b = BYTE_F0;
      3:       b = BYTE_W'($urandom_range(8'hf1, 8'hfe));
      default: b = BYTE_FF;
    endcase
    return b;
  endfunction

  // One frame: words, a terminating word (unless full), sync noise and the
  // end mark. One frame in ten is raw noise instead. Afterwards the stream is
  // realigned so the next frame starts at a clean word boundary.
  task automatic send_random_frame(input bit full);
    int unsigned      n_words;
    logic [VAL_W-1:0] w;
    if (!full && $urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 9)) send_byte(BYTE_W'($urandom_range(0, 255)), ROW_PRED, NO_RES);
    end else begin
      n_words = full ? FRAME_SLOTS - next_slot : $urandom_range(0, 24);
      repeat (n_words) begin
        case ($urandom_range(0, 5))
          0:       w = '0;
          1:       w = VAL_W'(FILL_LIMIT);
          default: w = VAL_W'($urandom_range(0, FILL_LIMIT));
        endcase
        send_word(w);
      end
      if (!full) begin
        if ($urandom_range(0, 1) != 0) w = VAL_W'(WORD_SYNC);
        else w = VAL_W'($urandom_range(FILL_LIMIT + 1, WORD_SYNC - 1));
        send_word(w);
      end
      repeat ($urandom_range(0, full ? 4 : 6)) send_byte(pick_class_byte(), ROW_PRED, NO_RES);
      send_end_mark();
    end
    if (!in_sync && high_due) send_byte(BYTE_00, ROW_PRED, NO_RES);
    while (in_sync) send_end_mark();
  endtask

  // ---------------------------------------------------------------------
  // Receiver: segments of always-ready, random and fixed-pattern stalls,
  // plus one long hold-off on request.
  // ---------------------------------------------------------------------
  initial begin
    int unsigned seg_mode;
    int unsigned rx_tick;
    m_axis_tready_i = 1'b0;
    rx_tick = 0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        seg_mode = $urandom_range(0, 3);
        repeat ($urandom_range(8, 64)) begin
          case (seg_mode)
            0:       m_axis_tready_i <= 1'b1;
            1:       m_axis_tready_i <= ($urandom_range(0, 3) != 0);
            2:       m_axis_tready_i <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready_i <= ((rx_tick % 7) < 4);
          endcase
          rx_tick++;
          @(negedge clk_i);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result checker: each accepted word against the oldest expected event.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    lfd_res_t want;
    lfd_res_t got;
    logic [OUT_TDATA_W-PAD_LSB-1:0] pad;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.evt   = evt_e'(m_axis_tdata_o[EVT_W-1:0]);
      got.index = m_axis_tdata_o[IDX_LSB +: IDX_W];
      got.value = m_axis_tdata_o[VAL_LSB +: VAL_W];
      pad       = m_axis_tdata_o[OUT_TDATA_W-1:PAD_LSB];
      if (slot_events_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("%0t: unexpected event: evt %0d index %0d value %h", $realtime,
                   got.evt, got.index, got.value);
      end else begin
        want = slot_events_q.pop_front();
        if (got.evt !== want.evt || got.index !== want.index ||
            got.value !== want.value || pad !== '0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("%0t: event mismatch: expected evt %0d index %0d value %h,",
                     $realtime, want.evt, want.index, want.value,
                     " got evt %0d index %0d value %h pad %h",
                     got.evt, got.index, got.value, pad);
        end
      end
    end
  end

  // Watchdog: too long with no word moving on either side ends the run.
  always @(posedge clk_i) begin
    int unsigned idle_cycles;
    if (!rst_ni) begin
      idle_cycles = 0;
    end else if ((s_axis_tvalid_i && s_axis_tready_o) ||
                 (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("led_frame_deframer_top_test failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus: reset, directed table, then random frames.
  // ---------------------------------------------------------------------
  initial begin
    int unsigned frame_no;
    int unsigned full_done;
    bit          full;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_byte(DIRECTED[i].data, DIRECTED[i].kind, DIRECTED[i].res);

    // One full frame at frame three, with the long receiver hold-off so the
    // block backs up into its input; a full drain before frame two.
    frame_no  = 0;
    full_done = 0;
    while (full_done < FULL_FRAMES || bytes_sent < RANDOM_BYTES) begin
      full = (frame_no % 12 == 3) && (full_done < FULL_FRAMES);
      if (full && full_done == 0) hold_req = 1'b1;
      if (frame_no == 2) wait_events_drained();
      send_random_frame(full);
      if (full) full_done++;
      frame_no++;
    end

    wait_events_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (mismatch_cnt == 0 && slot_events_q.size() == 0) begin
      $display("led_frame_deframer_top_test passed");
    end else begin
      $display("led_frame_deframer_top_test failed");
    end
    $finish;
  end

endmodule
